// ===== rtl/grc_pkg.sv =====
// shared constants for the greedy row coloring block
`timescale 1ns / 1ps

package grc_pkg;

  // width of row and neighbor indices on the ports
  localparam int unsigned IdxW = 16;

  // width of one stored color entry
  localparam int unsigned StoreW = 5;

  // used-color mask covers every color a stored entry can name
  localparam int unsigned MaskW = 32;

  // width of the color count on the result port
  localparam int unsigned CountW = 6;

endpackage

// ===== rtl/grc_fold.sv =====
// one slice of the restoring index reduction modulo the row store depth
`timescale 1ns / 1ps

module grc_fold #(
  parameter int unsigned MOD = 65536,
  parameter int unsigned HI  = 14,
  parameter int unsigned LO  = 0
) (
  input  logic [grc_pkg::IdxW-1:0] value_i,
  output logic [grc_pkg::IdxW-1:0] value_o
);

  logic [grc_pkg::IdxW-1:0] acc;

  // subtract the shifted modulus where it fits, highest shift first
  always_comb begin
    acc = value_i;
    for (int k = int'(HI); k >= int'(LO); k--) begin
      if (((64'(MOD) << k) <= 64'(16'hFFFF)) &&
          (64'(acc) >= (64'(MOD) << k))) begin
        acc = acc - grc_pkg::IdxW'(64'(MOD) << k);
      end
    end
  end

  assign value_o = acc;

endmodule

// ===== rtl/grc_color_ram.sv =====
// color store: one write port, one registered read port with write bypass
`timescale 1ns / 1ps

module grc_color_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [grc_pkg::StoreW-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [grc_pkg::StoreW-1:0] wr_data_i
);

  logic [grc_pkg::StoreW-1:0] mem [DEPTH];
  logic [grc_pkg::StoreW-1:0] rdata_q;
  logic [grc_pkg::StoreW-1:0] byp_data_q;
  logic                       byp_q;

  // storage array, read before write on a shared edge
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // remember when the read raced a write to the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rdata_q;

endmodule

// ===== rtl/grc_pick.sv =====
// first-fit color search over the used-color mask
`timescale 1ns / 1ps

module grc_pick #(
  parameter int unsigned MAX_COLORS = 32
) (
  input  logic [grc_pkg::MaskW-1:0]        mask_i,
  input  logic [$clog2(MAX_COLORS+1)-1:0]  total_i,
  output logic [$clog2(MAX_COLORS)-1:0]    color_o,
  output logic [$clog2(MAX_COLORS+1)-1:0]  total_o,
  output logic                             overflow_o
);

  localparam int unsigned TW = $clog2(MAX_COLORS + 1);
  localparam int unsigned CW = $clog2(MAX_COLORS);

  logic [MAX_COLORS-1:0] busy;
  logic                  found;

  assign busy = MAX_COLORS'(mask_i);

  // lowest existing color that no neighbor holds, else open a new one, or take the top color on overflow
  always_comb begin
    found      = 1'b0;
    color_o    = '0;
    total_o    = total_i;
    overflow_o = 1'b0;
    for (int j = 0; j < int'(MAX_COLORS); j++) begin
      if (!found && !busy[j] && (TW'(j) < total_i)) begin
        found   = 1'b1;
        color_o = CW'(j);
      end
    end
    if (!found) begin
      if (total_i >= TW'(MAX_COLORS)) begin
        color_o    = CW'(MAX_COLORS - 1);
        overflow_o = 1'b1;
      end else begin
        color_o = CW'(total_i);
        total_o = total_i + TW'(1);
      end
    end
  end

endmodule

// ===== rtl/greedy_row_coloring.sv =====
// top level of the greedy first-fit row coloring block
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   row_index, neighbor_index, has_neighbor,
//                                                 last_of_row
//   out      output     out_valid_o / out_stall_i colored_row, row_color, colors_in_use,
//                                                 color_overflow
//
// one transaction per cycle is accepted while in_stall_o is low; the transaction that ends
// its row passes stage 1 (index reduction), stage 2 (store read) and the output register
// the color store is never cleared: reset clears stage valids, output valid, mask and count only
// in_stall_o rises only when the output register holds a stalled result and the
// execute stage holds another; items that end no row never block
`timescale 1ns / 1ps

module greedy_row_coloring #(
  parameter int unsigned MAX_ROWS   = 65536,
  parameter int unsigned MAX_COLORS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [grc_pkg::IdxW-1:0]   row_index_i,
  input  logic [grc_pkg::IdxW-1:0]   neighbor_index_i,
  input  logic                       has_neighbor_i,
  input  logic                       last_of_row_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [grc_pkg::IdxW-1:0]   colored_row_o,
  output logic [grc_pkg::StoreW-1:0] row_color_o,
  output logic [grc_pkg::CountW-1:0] colors_in_use_o,
  output logic                       color_overflow_o
);

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned TW = $clog2(MAX_COLORS + 1);
  localparam int unsigned CW = $clog2(MAX_COLORS);
  localparam int unsigned IW = grc_pkg::IdxW;

  // pipeline advance
  logic adv;

  // stage 1: accepted item, indices partly reduced
  logic          v1_q;
  logic [IW-1:0] row1_q;
  logic [IW-1:0] rowf1_q;
  logic [IW-1:0] nbrf1_q;
  logic          hit1_q;
  logic          last1_q;
  logic          zero1_q;
  logic [IW-1:0] rowf1_d;
  logic [IW-1:0] nbrf1_d;

  // stage 2: execute, neighbor color arrives from the store
  logic          v2_q;
  logic [IW-1:0] row2_q;
  logic [AW-1:0] rowaddr2_q;
  logic          hit2_q;
  logic          last2_q;
  logic          zero2_q;
  logic [IW-1:0] rowf2;
  logic [IW-1:0] nbrf2;

  // coloring state
  logic [grc_pkg::MaskW-1:0] mask_q;
  logic [grc_pkg::MaskW-1:0] mask_d;
  logic [TW-1:0]             total_q;
  logic [TW-1:0]             total_d;
  logic [TW-1:0]             total_cur;
  logic [TW-1:0]             total_new;
  logic [CW-1:0]             pick_color;
  logic                      pick_ovf;
  logic [grc_pkg::StoreW-1:0] nbr_color;
  logic                      assign_en;

  // output register
  logic                       out_valid_q;
  logic [IW-1:0]              colored_row_q;
  logic [grc_pkg::StoreW-1:0] row_color_q;
  logic [grc_pkg::CountW-1:0] count_q;
  logic                       ovf_q;

  // hold everything only when a second result would collide with a stalled one
  assign adv        = !(v2_q && last2_q && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign assign_en  = adv && v2_q && last2_q;

  // index reduction, first half in front of stage 1
  grc_fold #(.MOD(MAX_ROWS), .HI(14), .LO(8)) u_fold_row1 (
    .value_i (row_index_i),
    .value_o (rowf1_d)
  );

  grc_fold #(.MOD(MAX_ROWS), .HI(14), .LO(8)) u_fold_nbr1 (
    .value_i (neighbor_index_i),
    .value_o (nbrf1_d)
  );

  // index reduction, second half in front of the store
  grc_fold #(.MOD(MAX_ROWS), .HI(7), .LO(0)) u_fold_row2 (
    .value_i (rowf1_q),
    .value_o (rowf2)
  );

  grc_fold #(.MOD(MAX_ROWS), .HI(7), .LO(0)) u_fold_nbr2 (
    .value_i (nbrf1_q),
    .value_o (nbrf2)
  );

  // color store, read entering execute, written by execute
  grc_color_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv),
    .rd_addr_i (AW'(nbrf2)),
    .rd_data_o (nbr_color),
    .wr_en_i   (assign_en),
    .wr_addr_i (rowaddr2_q),
    .wr_data_i (grc_pkg::StoreW'(pick_color))
  );

  // gather the neighbor color and apply a restart on row zero
  always_comb begin
    total_cur = zero2_q ? '0 : total_q;
    mask_d    = mask_q;
    if (hit2_q) begin
      mask_d = mask_q | (grc_pkg::MaskW'(1) << nbr_color);
    end
  end

  grc_pick #(.MAX_COLORS(MAX_COLORS)) u_pick (
    .mask_i     (mask_d),
    .total_i    (total_cur),
    .color_o    (pick_color),
    .total_o    (total_new),
    .overflow_o (pick_ovf)
  );

  assign total_d = last2_q ? total_new : total_cur;

  // stage valids and coloring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      mask_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= in_valid_i;
        v2_q <= v1_q;
        if (v2_q) begin
          mask_q  <= last2_q ? '0 : mask_d;
          total_q <= total_d;
        end
      end
      if (assign_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q     <= row_index_i;
      rowf1_q    <= rowf1_d;
      nbrf1_q    <= nbrf1_d;
      hit1_q     <= has_neighbor_i && (neighbor_index_i < row_index_i);
      last1_q    <= last_of_row_i;
      zero1_q    <= (row_index_i == '0);
      row2_q     <= row1_q;
      rowaddr2_q <= AW'(rowf2);
      hit2_q     <= hit1_q;
      last2_q    <= last1_q;
      zero2_q    <= zero1_q;
    end
    if (assign_en) begin
      colored_row_q <= row2_q;
      row_color_q   <= grc_pkg::StoreW'(pick_color);
      count_q       <= grc_pkg::CountW'(total_new);
      ovf_q         <= pick_ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign colored_row_o    = colored_row_q;
  assign row_color_o      = row_color_q;
  assign colors_in_use_o  = count_q;
  assign color_overflow_o = ovf_q;

`ifndef NO_ASSERTIONS
  // color count never passes the configured maximum
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_COLORS))
    else $error("color count above maximum");

  // an overflowing row takes the top color with a full count
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    assign_en && pick_ovf |=> row_color_o == grc_pkg::StoreW'(MAX_COLORS - 1) &&
      colors_in_use_o == grc_pkg::CountW'(MAX_COLORS))
    else $error("overflow result not saturated");

  // input is held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && v2_q && last2_q)
    else $error("input stalled without a blocked result");

  // the used-color mask starts empty after every assignment
  a_mask_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    assign_en |=> mask_q == '0)
    else $error("mask not cleared after assignment");

  // a stalled execute stage leaves the coloring state alone
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(mask_q) && $stable(total_q))
    else $error("state changed during a stall");
`endif

endmodule

// ===== sim/greedy_row_coloring_tb.sv =====
// self-checking testbench for the greedy first-fit row coloring block
`timescale 1ns / 1ps

module greedy_row_coloring_tb;

  localparam int unsigned RandomItems = 757;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned ColorLimit  = 32;
  localparam int unsigned LimitNs     = 2_000_000;

  typedef logic [grc_pkg::IdxW-1:0] idx_t;

  // one expected coloring result
  typedef struct packed {
    idx_t                       row;
    logic [grc_pkg::StoreW-1:0] color;
    logic [grc_pkg::CountW-1:0] count;
    logic                       overflow;
  } coloring_t;

  // idling styles for both sides
  typedef enum int { IDLE_NONE, IDLE_FULL, IDLE_SPARSE } idle_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  idx_t                       row_index_i = '0;
  idx_t                       neighbor_index_i = '0;
  logic                       has_neighbor_i = 1'b0;
  logic                       last_of_row_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  idx_t                       colored_row_o;
  logic [grc_pkg::StoreW-1:0] row_color_o;
  logic [grc_pkg::CountW-1:0] colors_in_use_o;
  logic                       color_overflow_o;

  // predictor state: stored colors, mask of colors taken by lower neighbors, count
  logic [grc_pkg::StoreW-1:0] color_mem [0:65535];
  bit                         colored [0:65535];
  logic [grc_pkg::MaskW-1:0]  taken_colors = '0;
  int unsigned                color_count = 0;
  coloring_t                  expected_colorings [$];
  idx_t                       recent_rows [$];

  idle_mode_e  send_idle = IDLE_NONE;
  idle_mode_e  recv_idle = IDLE_NONE;
  logic        hold_output = 1'b0;
  int unsigned recv_wait = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned rows_colored = 0;
  int unsigned overflow_rows = 0;
  int unsigned peak_colors = 0;
  int unsigned input_stall_cycles = 0;

  greedy_row_coloring uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .row_index_i      (row_index_i),
    .neighbor_index_i (neighbor_index_i),
    .has_neighbor_i   (has_neighbor_i),
    .last_of_row_i    (last_of_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .colored_row_o    (colored_row_o),
    .row_color_o      (row_color_o),
    .colors_in_use_o  (colors_in_use_o),
    .color_overflow_o (color_overflow_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // wait length for one transaction under an idling style
  function automatic int unsigned draw_wait(idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 19);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  // first-fit color prediction for one accepted transaction
  task automatic predict_coloring(input idx_t row, input idx_t nbr, input logic has,
                                  input logic last_item);
    coloring_t   result;
    int unsigned j;
    logic        found;
    found = 1'b0;
    if (row == 0) color_count = 0;
    if (has && nbr < row) taken_colors |= 32'd1 << color_mem[nbr];
    if (last_item) begin
      result.row = row;
      result.overflow = 1'b0;
      result.color = '0;
      for (j = 0; j < color_count && !found; j++) begin
        if (!taken_colors[j]) begin
          result.color = j[grc_pkg::StoreW-1:0];
          found = 1'b1;
        end
      end
      // every existing color taken: open a new one or saturate
      if (!found) begin
        if (color_count >= ColorLimit) begin
          result.color = grc_pkg::StoreW'(ColorLimit - 1);
          result.overflow = 1'b1;
          overflow_rows++;
        end else begin
          result.color = color_count[grc_pkg::StoreW-1:0];
          color_count++;
        end
      end
      result.count = color_count[grc_pkg::CountW-1:0];
      color_mem[row] = result.color;
      colored[row] = 1'b1;
      taken_colors = '0;
      expected_colorings.insert(expected_colorings.size(), result);
      rows_colored++;
      if (color_count > peak_colors) peak_colors = color_count;
      recent_rows.insert(recent_rows.size(), row);
      if (recent_rows.size() > 32) void'(recent_rows.pop_front());
    end
  endtask

  // send one transaction, called at a rising edge, returns at the accepting edge
  task automatic send_nonzero(input idx_t row, input idx_t nbr, input logic has,
                              input logic last_item);
    int unsigned gap;
    gap = draw_wait(send_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    row_index_i      <= row;
    neighbor_index_i <= nbr;
    has_neighbor_i   <= has;
    last_of_row_i    <= last_item;
    do @(posedge clk_i); while (in_stall_o);
    predict_coloring(row, nbr, has, last_item);
    items_sent++;
  endtask

  // neighbor for a random transaction; never reads a row that was never colored
  task automatic pick_neighbor(input idx_t row, output idx_t nbr, output logic has);
    int unsigned reach;
    case ($urandom_range(0, 9))
      0, 1: begin
        has = 1'b0;
        nbr = idx_t'($urandom());
      end
      2, 3: begin
        has = 1'b1;
        nbr = idx_t'($urandom_range(row, 65535));
      end
      default: begin
        has = 1'b1;
        if (recent_rows.size() > 0) begin
          reach = (recent_rows.size() < 12) ? recent_rows.size() : 12;
          nbr = recent_rows[recent_rows.size() - 1 - $urandom_range(0, reach - 1)];
        end else begin
          nbr = idx_t'($urandom());
        end
      end
    endcase
    if (has && nbr < row && !colored[nbr]) has = 1'b0;
  endtask

  // one row of random nonzeros, now and then with a stray row index
  task automatic color_random_row(input idx_t row);
    int   n;
    int   k;
    idx_t r;
    idx_t nbr;
    logic has;
    n = $urandom_range(1, 5);
    for (k = 0; k < n; k++) begin
      r = ($urandom_range(0, 15) == 0) ? idx_t'($urandom()) : row;
      pick_neighbor(r, nbr, has);
      send_nonzero(r, nbr, has, k == n - 1);
    end
  endtask

  // lowest free color, new colors, ignored upper and self neighbors, empty items
  task automatic test_first_fit();
    send_idle = IDLE_FULL;
    recv_idle = IDLE_FULL;
    send_nonzero(16'd0, 16'h0000, 1'b0, 1'b1);
    send_nonzero(16'd1, 16'd0, 1'b1, 1'b1);
    send_nonzero(16'd2, 16'd0, 1'b1, 1'b0);
    send_nonzero(16'd2, 16'd1, 1'b1, 1'b0);
    send_nonzero(16'd2, 16'd5, 1'b1, 1'b1);
    send_nonzero(16'd3, 16'd1, 1'b1, 1'b0);
    send_nonzero(16'd3, 16'hFFFF, 1'b0, 1'b1);
    send_nonzero(16'd4, 16'd3, 1'b1, 1'b0);
    send_nonzero(16'd4, 16'd4, 1'b1, 1'b0);
    send_nonzero(16'd4, 16'hFFFF, 1'b1, 1'b1);
  endtask

  // row 0 restarts the count, old colors above the count are ignored
  task automatic test_restart_stale_colors();
    send_nonzero(16'd0, 16'd0, 1'b0, 1'b1);
    send_nonzero(16'd5, 16'd2, 1'b1, 1'b0);
    send_nonzero(16'd5, 16'd0, 1'b1, 1'b1);
  endtask

  // a row below the previous one and the top row index
  task automatic test_out_of_order_rows();
    send_nonzero(16'd3, 16'd1, 1'b1, 1'b1);
    send_nonzero(16'hFFFF, 16'd0, 1'b1, 1'b0);
    send_nonzero(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_nonzero(16'hFFFF, 16'd5, 1'b1, 1'b1);
  endtask

  // a row 0 transaction inside another row clears the count but not the mask
  task automatic test_mid_row_restart();
    send_nonzero(16'd7, 16'd5, 1'b1, 1'b0);
    send_nonzero(16'd0, 16'hAAAA, 1'b0, 1'b0);
    send_nonzero(16'd7, 16'h5555, 1'b1, 1'b1);
  endtask

  // clique of rows: every row needs a new color until the limit saturates
  task automatic test_color_overflow();
    int k;
    int m;
    send_idle = IDLE_SPARSE;
    recv_idle = IDLE_SPARSE;
    send_nonzero(16'd0, 16'd0, 1'b0, 1'b1);
    for (k = 1; k <= ColorLimit + 1; k++) begin
      for (m = 0; m < k; m++) send_nonzero(idx_t'(k), idx_t'(m), 1'b1, m == k - 1);
    end
    // neighbors hold only the lower colors, so the top color is free again
    for (m = 0; m < ColorLimit - 1; m++) begin
      send_nonzero(idx_t'(ColorLimit + 2), idx_t'(m), 1'b1, m == ColorLimit - 2);
    end
  endtask

  // long output hold while the sender keeps offering rows back to back
  task automatic test_output_backpressure();
    int k;
    send_idle = IDLE_NONE;
    recv_idle = IDLE_NONE;
    fork
      begin
        hold_output <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_output <= 1'b0;
      end
      begin
        send_nonzero(16'd0, 16'd0, 1'b0, 1'b1);
        for (k = 1; k < 80; k++) send_nonzero(idx_t'(k), idx_t'(k - 1), 1'b1, 1'b1);
      end
    join
  endtask

  // random graphs: dense rows, restarts, jumps, out of order rows and stray items
  task automatic test_random_graphs();
    int unsigned first_item;
    int unsigned row;
    int unsigned span;
    int unsigned k;
    first_item = items_sent;
    row = 0;
    while (items_sent - first_item < RandomItems) begin
      send_idle = idle_mode_e'($urandom_range(0, 2));
      recv_idle = idle_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0 || row > 65000) row = 0;
      span = $urandom_range(5, 40);
      for (k = 0; k < span && items_sent - first_item < RandomItems; k++) begin
        color_random_row(idx_t'(row));
        case ($urandom_range(0, 19))
          0:       row = row + $urandom_range(100, 20000);
          1:       row = (row > 3) ? row - $urandom_range(1, 3) : row + 1;
          default: row = row + $urandom_range(1, 3);
        endcase
        if (row > 65535) row = 65535;
      end
    end
  endtask

  // field compare with report
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result check and receiver stall
  always @(posedge clk_i) begin : result_monitor
    coloring_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colorings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d color %0d",
                 $time, colored_row_o, row_color_o);
        errors++;
      end else begin
        want = expected_colorings.pop_front();
        compare_field("colored_row", 32'(want.row), 32'(colored_row_o));
        compare_field("row_color", 32'(want.color), 32'(row_color_o));
        compare_field("colors_in_use", 32'(want.count), 32'(colors_in_use_o));
        compare_field("color_overflow", 32'(want.overflow), 32'(color_overflow_o));
      end
      recv_wait = draw_wait(recv_idle);
    end
    if (hold_output) begin
      out_stall_i <= 1'b1;
    end else if (recv_wait > 0) begin
      out_stall_i <= 1'b1;
      recv_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // test sequence
  initial begin : main_sequence
    int unsigned guard;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_fit();
    test_restart_stale_colors();
    test_out_of_order_rows();
    test_mid_row_restart();
    test_color_overflow();
    test_output_backpressure();
    test_random_graphs();
    in_valid_i <= 1'b0;
    // drain outstanding results, then let the pipeline settle
    guard = 0;
    while (expected_colorings.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_colorings.size() != 0) begin
      $display("%0t: %0d expected results never arrived, first row %0d", $time,
               expected_colorings.size(), expected_colorings[0].row);
      errors += expected_colorings.size();
    end
    $display("covered %0d input transactions, %0d rows colored, %0d past the color limit",
             items_sent, rows_colored, overflow_rows);
    $display("peak colors in use %0d, input held off for %0d cycles",
             peak_colors, input_stall_cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(LimitNs);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/grc_pkg.sv
rtl/grc_fold.sv
rtl/grc_color_ram.sv
rtl/grc_pick.sv
rtl/greedy_row_coloring.sv
sim/greedy_row_coloring_tb.sv
